>>> src/dpf_pkg.sv
// Shared types, constants and the CRC byte update for the duty packet framer.
package dpf_pkg;

    localparam int unsigned CFG_REGS   = 7;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned IDX_W      = 3;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_START   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SETDUTY = 3'd1;
    localparam logic [IDX_W-1:0] REG_FORWARD = 3'd2;
    localparam logic [IDX_W-1:0] REG_REMOTE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_END     = 3'd4;
    localparam logic [IDX_W-1:0] REG_END2    = 3'd5;
    localparam logic [IDX_W-1:0] REG_POLY    = 3'd6;

    localparam logic [7:0]  RST_START   = 8'd2;
    localparam logic [7:0]  RST_SETDUTY = 8'd5;
    localparam logic [7:0]  RST_FORWARD = 8'd34;
    localparam logic [7:0]  RST_REMOTE  = 8'd1;
    localparam logic [7:0]  RST_END     = 8'd3;
    localparam logic [7:0]  RST_END2    = 8'd3;
    localparam logic [15:0] RST_POLY    = 16'h1021;

    localparam logic [7:0]  LEN_DIRECT  = 8'd5;
    localparam logic [7:0]  LEN_FORWARD = 8'd7;

    typedef struct packed {
        logic        mode;
        logic [31:0] duty;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  set_duty_code;
        logic [7:0]  forward_code;
        logic [7:0]  remote_id;
        logic [7:0]  end_marker;
        logic [7:0]  end_marker_two;
        logic [15:0] crc_polynomial;
    } t_cfg;

    // One payload byte into an MSB-first CRC-16.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/dpf_stream_if.sv
// Stream interfaces for duty commands in and packet bytes out.
interface dpf_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] duty;

    modport source (output valid, output mode, output duty, input ready);
    modport sink   (input valid, input mode, input duty, output ready);
endinterface

interface dpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

>>> src/dpf_front.sv
// Command front end: accepts duty commands into a two-entry queue.
module dpf_front
    import dpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dpf_in_if.sink      i_in,
    output t_cmd        o_head,
    output logic        o_head_valid,
    input  logic        i_pop
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;

    assign i_in.ready   = (r_count != 2'd2);
    assign w_push       = i_in.valid && i_in.ready;
    assign o_head_valid = (r_count != 2'd0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr].mode <= i_in.mode;
            r_mem[r_wr_ptr].duty <= i_in.duty;
        end
    end

endmodule

>>> src/dpf_back.sv
// Packet back end: byte sequencer, running CRC and output register.
module dpf_back
    import dpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_head,
    input  logic        i_head_valid,
    output logic        o_pop,
    dpf_out_if.source   o_out
);

    localparam logic [3:0] SL_LEN  = 4'd1;
    localparam logic [3:0] SL_FWD  = 4'd2;
    localparam logic [3:0] SL_RID  = 4'd3;
    localparam logic [3:0] SL_CMD  = 4'd4;
    localparam logic [3:0] SL_D3   = 4'd5;
    localparam logic [3:0] SL_D2   = 4'd6;
    localparam logic [3:0] SL_D1   = 4'd7;
    localparam logic [3:0] SL_D0   = 4'd8;
    localparam logic [3:0] SL_CRCH = 4'd9;
    localparam logic [3:0] SL_CRCL = 4'd10;
    localparam logic [3:0] SL_END1 = 4'd11;
    localparam logic [3:0] SL_END2 = 4'd12;

    logic        r_busy;
    logic [3:0]  r_slot;
    logic        r_mode;
    logic [31:0] r_duty;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        w_adv;
    logic [7:0]  w_byte;
    logic        w_is_payload;
    logic [3:0]  n_slot;

    assign w_adv = !r_out_valid || o_out.ready;
    assign o_pop = w_adv && !r_busy && i_head_valid;

    always_comb begin
        unique case (r_slot)
            SL_LEN:  w_byte = r_mode ? LEN_FORWARD : LEN_DIRECT;
            SL_FWD:  w_byte = i_cfg.forward_code;
            SL_RID:  w_byte = i_cfg.remote_id;
            SL_CMD:  w_byte = i_cfg.set_duty_code;
            SL_D3:   w_byte = r_duty[31:24];
            SL_D2:   w_byte = r_duty[23:16];
            SL_D1:   w_byte = r_duty[15:8];
            SL_D0:   w_byte = r_duty[7:0];
            SL_CRCH: w_byte = r_crc[15:8];
            SL_CRCL: w_byte = r_crc[7:0];
            SL_END1: w_byte = i_cfg.end_marker;
            SL_END2: w_byte = i_cfg.end_marker_two;
            default: w_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (r_slot) inside
            SL_FWD, SL_RID, SL_CMD, SL_D3, SL_D2, SL_D1, SL_D0: w_is_payload = 1'b1;
            default:                                            w_is_payload = 1'b0;
        endcase
    end

    // A direct packet skips the forward code and remote id.
    assign n_slot = (r_slot == SL_LEN && !r_mode) ? SL_CMD : r_slot + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= SL_LEN;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_busy || i_head_valid;
            if (r_busy) begin
                r_slot <= n_slot;
                if (r_slot == SL_END2) begin
                    r_busy <= 1'b0;
                end
            end else if (i_head_valid) begin
                r_busy <= 1'b1;
                r_slot <= SL_LEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_busy) begin
                r_out_byte <= w_byte;
                r_out_last <= (r_slot == SL_END2);
                if (w_is_payload) begin
                    r_crc <= crc_feed(r_crc, w_byte, i_cfg.crc_polynomial);
                end
            end else if (i_head_valid) begin
                r_out_byte <= i_cfg.start_marker;
                r_out_last <= 1'b0;
                r_mode     <= i_head.mode;
                r_duty     <= i_head.duty;
                r_crc      <= 16'h0000;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.packet_byte = r_out_byte;
    assign o_out.last_byte   = r_out_last;

endmodule

>>> src/duty_packet_framer_crc16.sv
// Top level of the duty packet framer: configuration registers and the two halves.
//
// Each accepted duty command becomes one serial packet on the output stream, one byte
// per transaction and one byte per cycle while the sink keeps ready high: a direct
// command gives 11 bytes and a forwarded command 13; the back-end byte sequencer
// sends them in turn and packets follow each other without a gap.
// A two-entry command queue in front of the sequencer takes up to two further commands
// while a packet is being sent. The CRC-16 (MSB first, initial value zero) covers the
// payload bytes only and is updated one byte per cycle as they leave, unless the
// sink stalls. Registers are written over the APB port at byte address 4*index and
// should be changed only while no packet is pending.
module duty_packet_framer_crc16
    import dpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dpf_in_if.sink            i_in,
    dpf_out_if.source         o_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready
);

    t_cfg             r_cfg;
    logic             w_wr;
    logic [IDX_W-1:0] w_idx;
    t_cmd             w_head;
    logic             w_head_valid;
    logic             w_pop;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign w_idx    = i_paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker   <= RST_START;
            r_cfg.set_duty_code  <= RST_SETDUTY;
            r_cfg.forward_code   <= RST_FORWARD;
            r_cfg.remote_id      <= RST_REMOTE;
            r_cfg.end_marker     <= RST_END;
            r_cfg.end_marker_two <= RST_END2;
            r_cfg.crc_polynomial <= RST_POLY;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_START:   r_cfg.start_marker   <= i_pwdata[7:0];
                REG_SETDUTY: r_cfg.set_duty_code  <= i_pwdata[7:0];
                REG_FORWARD: r_cfg.forward_code   <= i_pwdata[7:0];
                REG_REMOTE:  r_cfg.remote_id      <= i_pwdata[7:0];
                REG_END:     r_cfg.end_marker     <= i_pwdata[7:0];
                REG_END2:    r_cfg.end_marker_two <= i_pwdata[7:0];
                REG_POLY:    r_cfg.crc_polynomial <= i_pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_START:   o_prdata = {24'h0, r_cfg.start_marker};
            REG_SETDUTY: o_prdata = {24'h0, r_cfg.set_duty_code};
            REG_FORWARD: o_prdata = {24'h0, r_cfg.forward_code};
            REG_REMOTE:  o_prdata = {24'h0, r_cfg.remote_id};
            REG_END:     o_prdata = {24'h0, r_cfg.end_marker};
            REG_END2:    o_prdata = {24'h0, r_cfg.end_marker_two};
            REG_POLY:    o_prdata = {16'h0, r_cfg.crc_polynomial};
            default:     o_prdata = 32'h0;
        endcase
    end

    dpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    dpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the duty packet framer: command stimulus, byte checking, APB setup.
`timescale 1ns / 100ps

module testbench;
    import dpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PAUSE_CYCLES   = 16;
    localparam int DRAIN_CYCLES   = 32;
    localparam int PHASES         = 5;

    // First address past the register file; writes there must be dropped.
    localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(CFG_REGS);

    typedef enum int {SET_RESET, SET_ONES, SET_ZEROS, SET_RANDOM, SET_RANDOM_SPARE} t_setting;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic i_clk;
    logic i_rst_n;
    logic              i_psel;
    logic              i_penable;
    logic              i_pwrite;
    logic [ADDR_W-1:0] i_paddr;
    logic [31:0]       i_pwdata;
    logic [31:0]       o_prdata;
    logic              o_pready;

    dpf_in_if  cmd_if();
    dpf_out_if byte_if();

    duty_packet_framer_crc16 dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (cmd_if),
        .o_out     (byte_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    t_cfg        frame_cfg;
    t_cmd        cmd_pending_q[$];
    t_frame_byte frame_bytes_q[$];
    t_cmd        next_cmd;
    logic        cmd_fire;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          err_count;
    int          idle_cycles;
    int          cmds_direct;
    int          cmds_forward;
    int          bytes_checked;
    int          reg_writes;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data,
                                               input logic [15:0] poly);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ data[k];
            c  = {c[14:0], 1'b0} ^ (fb ? poly : 16'h0000);
        end
        return c;
    endfunction

    // Expected packet bytes for one command under the current register settings.
    function automatic void push_packet(input logic mode, input logic [31:0] duty);
        logic [7:0]  payload[$];
        logic [7:0]  frame[$];
        logic [15:0] crc;
        t_frame_byte fb;
        crc = 16'h0000;
        if (mode) begin
            payload.insert(payload.size(), frame_cfg.forward_code);
            payload.insert(payload.size(), frame_cfg.remote_id);
        end
        payload.insert(payload.size(), frame_cfg.set_duty_code);
        for (int s = 3; s >= 0; s--) begin
            payload.insert(payload.size(), duty[8*s +: 8]);
        end
        frame.insert(frame.size(), frame_cfg.start_marker);
        frame.insert(frame.size(), 8'(payload.size()));
        foreach (payload[i]) begin
            frame.insert(frame.size(), payload[i]);
            crc = crc16_step(crc, payload[i], frame_cfg.crc_polynomial);
        end
        frame.insert(frame.size(), crc[15:8]);
        frame.insert(frame.size(), crc[7:0]);
        frame.insert(frame.size(), frame_cfg.end_marker);
        frame.insert(frame.size(), frame_cfg.end_marker_two);
        foreach (frame[i]) begin
            fb.data = frame[i];
            fb.last = (i == frame.size() - 1);
            frame_bytes_q.insert(frame_bytes_q.size(), fb);
        end
    endfunction

    function automatic void cfg_apply(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        case (idx)
            REG_START:   frame_cfg.start_marker   = value[7:0];
            REG_SETDUTY: frame_cfg.set_duty_code  = value[7:0];
            REG_FORWARD: frame_cfg.forward_code   = value[7:0];
            REG_REMOTE:  frame_cfg.remote_id      = value[7:0];
            REG_END:     frame_cfg.end_marker     = value[7:0];
            REG_END2:    frame_cfg.end_marker_two = value[7:0];
            REG_POLY:    frame_cfg.crc_polynomial = value[15:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] cfg_value(input logic [IDX_W-1:0] idx);
        case (idx)
            REG_START:   return {24'd0, frame_cfg.start_marker};
            REG_SETDUTY: return {24'd0, frame_cfg.set_duty_code};
            REG_FORWARD: return {24'd0, frame_cfg.forward_code};
            REG_REMOTE:  return {24'd0, frame_cfg.remote_id};
            REG_END:     return {24'd0, frame_cfg.end_marker};
            REG_END2:    return {24'd0, frame_cfg.end_marker_two};
            REG_POLY:    return {16'd0, frame_cfg.crc_polynomial};
            default:     return 32'd0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch on %s: got 0x%0h, expected 0x%0h (byte %0d)",
                 what, got, want, bytes_checked);
        err_count++;
    endtask

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = ADDR_W'({idx, 2'b00});
        i_pwdata  = value;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        cfg_apply(idx, value);
        reg_writes++;
    endtask

    task automatic apb_read_check(input logic [IDX_W-1:0] idx);
        logic [31:0] got;
        @(negedge i_clk);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
        i_paddr   = ADDR_W'({idx, 2'b00});
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        got = o_prdata;
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        if (got !== cfg_value(idx)) begin
            report_mismatch($sformatf("register %0d readback", idx), got, cfg_value(idx));
        end
    endtask

    // Upper bits of every write carry junk so that the register masking is exercised.
    task automatic load_setting(input t_setting setting);
        logic [31:0] value;
        for (int r = 0; r < CFG_REGS; r++) begin
            value = $urandom;
            case (setting)
                SET_ONES:  value[15:0] = 16'hFFFF;
                SET_ZEROS: value[15:0] = 16'h0000;
                default: ;
            endcase
            if (setting != SET_RESET) begin
                apb_write(IDX_W'(r), value);
            end
        end
        if (setting == SET_RANDOM_SPARE) begin
            apb_write(REG_SPARE, $urandom);
        end
        for (int r = 0; r < CFG_REGS; r++) begin
            apb_read_check(IDX_W'(r));
        end
    endtask

    task automatic queue_random_cmds(input int count);
        t_cmd c;
        for (int n = 0; n < count; n++) begin
            c.mode = 1'($urandom_range(1));
            c.duty = $urandom;
            cmd_pending_q.insert(cmd_pending_q.size(), c);
        end
    endtask

    task automatic queue_directed_cmds();
        logic [31:0] duties[9];
        t_cmd c;
        duties = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd100000, -32'sd100000};
        foreach (duties[i]) begin
            for (int m = 0; m < 2; m++) begin
                c.mode = 1'(m);
                c.duty = duties[i];
                cmd_pending_q.insert(cmd_pending_q.size(), c);
            end
        end
    endtask

    // Command driver: a transaction offered stays put until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(cmd_if.valid && !cmd_fire)) begin
                if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = cmd_pending_q.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.mode  <= next_cmd.mode;
                    cmd_if.duty  <= next_cmd.duty;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
            byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Prediction comes first so a byte leaving on the edge its command is taken is covered.
    always @(posedge i_clk) begin
        t_frame_byte want;
        cmd_fire <= i_rst_n && cmd_if.valid && cmd_if.ready;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            push_packet(cmd_if.mode, cmd_if.duty);
            if (cmd_if.mode) begin
                cmds_forward++;
            end else begin
                cmds_direct++;
            end
        end
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            if (frame_bytes_q.size() == 0) begin
                report_mismatch("unexpected packet byte", {24'd0, byte_if.packet_byte}, 32'd0);
            end else begin
                want = frame_bytes_q.pop_front();
                if (byte_if.packet_byte !== want.data) begin
                    report_mismatch("packet_byte", {24'd0, byte_if.packet_byte},
                                    {24'd0, want.data});
                end
                if (byte_if.last_byte !== want.last) begin
                    report_mismatch("last_byte", {31'd0, byte_if.last_byte}, {31'd0, want.last});
                end
            end
            bytes_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (byte_if.valid && byte_if.ready) || i_psel ||
            !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired with %0d bytes outstanding", frame_bytes_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_setting settings[PHASES];
        int       random_counts[PHASES];
        settings      = '{SET_RESET, SET_ONES, SET_ZEROS, SET_RANDOM, SET_RANDOM_SPARE};
        random_counts = '{50, 70, 70, 80, 70};
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_psel         = 1'b0;
        i_penable      = 1'b0;
        i_pwrite       = 1'b0;
        i_paddr        = '0;
        i_pwdata       = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.mode    = 1'b0;
        cmd_if.duty    = '0;
        byte_if.ready  = 1'b0;
        cmd_fire       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_count      = 0;
        idle_cycles    = 0;
        cmds_direct    = 0;
        cmds_forward   = 0;
        bytes_checked  = 0;
        reg_writes     = 0;
        frame_cfg = '{start_marker: RST_START, set_duty_code: RST_SETDUTY,
                      forward_code: RST_FORWARD, remote_id: RST_REMOTE, end_marker: RST_END,
                      end_marker_two: RST_END2, crc_polynomial: RST_POLY};
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            load_setting(settings[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (p == 0) begin
                queue_directed_cmds();
            end
            queue_random_cmds(random_counts[p]);
            while (cmd_pending_q.size() != 0 || cmd_if.valid || frame_bytes_q.size() != 0) begin
                @(negedge i_clk);
            end
            repeat (PAUSE_CYCLES) @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d direct and %0d forwarded commands, %0d packet bytes checked",
                 cmds_direct, cmds_forward, bytes_checked);
        $display("tb: %0d register writes over %0d settings, %0d mismatches",
                 reg_writes, PHASES, err_count);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
src/dpf_pkg.sv
src/dpf_stream_if.sv
src/dpf_front.sv
src/dpf_back.sv
src/duty_packet_framer_crc16.sv
tb/testbench.sv
